FILE: src/vde_pkg.sv
// Shared types, widths and codes of the vector distance engine.
package vde_pkg;

    localparam int OPW   = 48;          // multiplier operand width
    localparam int PRODW = 2 * OPW;     // multiplier product width
    localparam int DIVW  = PRODW + 32;  // dividend width, product shifted by 32
    localparam int QW    = 33;          // quotient width of the cosine divide
    localparam int RADW  = 96;          // square root radicand width
    localparam int ROOTW = RADW / 2;    // square root result width
    localparam int REMW  = ROOTW + 4;   // square root partial remainder width
    localparam int CNTW  = 6;           // iteration counter width
    localparam int VALW  = 48;          // result value width
    localparam int QCW   = 17;          // cosine magnitude width, up to 65536

    localparam logic [1:0] ST_VALID     = 2'd0;
    localparam logic [1:0] ST_ZERO_NORM = 2'd1;
    localparam logic [1:0] ST_BOUND     = 2'd2;

    localparam logic [1:0] MODE_L1  = 2'd0;
    localparam logic [1:0] MODE_L2  = 2'd1;
    localparam logic [1:0] MODE_COS = 2'd2;
    localparam logic [1:0] MODE_NVD = 2'd3;

    typedef enum logic [2:0] {
        OP_MUL_DOT   = 3'd0,
        OP_MUL_NORM  = 3'd1,
        OP_DIV       = 3'd2,
        OP_SQRT_SSD  = 3'd3,
        OP_SQRT_COS  = 3'd4,
        OP_SQRT_NVD  = 3'd5
    } math_op_t;

    typedef enum logic [1:0] {
        FIN_ZERO = 2'd0,
        FIN_L1   = 2'd1,
        FIN_ROOT = 2'd2,
        FIN_COS  = 2'd3
    } fin_sel_t;

    typedef struct packed {
        logic       start;
        math_op_t   op;
        logic       load_out;
        fin_sel_t   fin;
        logic [1:0] status;
        logic       clear_acc;
        logic       accept_en;
    } vde_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic out_free;
    } math_stat_t;

    typedef struct packed {
        logic done;
        logic bound;
        logic zero_norm;
    } acc_stat_t;

endpackage

FILE: src/vde_accum.sv
// Element pair product stage and the five running sums.
module vde_accum
    import vde_pkg::*;
#(
    parameter int MAX_LENGTH = 1024
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,
    input  logic                            s_tlast,
    input  vde_cmd_t                        cmd,
    output acc_stat_t                       stat,
    output logic [16+$clog2(MAX_LENGTH+1)-1:0] sad,
    output logic [32+$clog2(MAX_LENGTH+1)-1:0] ssd,
    output logic signed [32+$clog2(MAX_LENGTH+1)-1:0] dot,
    output logic [31+$clog2(MAX_LENGTH+1)-1:0] na,
    output logic [31+$clog2(MAX_LENGTH+1)-1:0] nb
);

    localparam int CW   = $clog2(MAX_LENGTH + 1);
    localparam int SADW = 16 + CW;
    localparam int SSDW = 32 + CW;
    localparam int DOTW = 32 + CW;
    localparam int NRMW = 31 + CW;

    logic signed [15:0] a, b;
    logic signed [16:0] d;
    logic signed [33:0] dsq;
    logic signed [31:0] ab, aa, bb;
    logic [15:0]        absd;

    logic               p1_valid_reg, p1_last_reg;
    logic [15:0]        p1_abs_reg;
    logic [31:0]        p1_sq_reg;
    logic signed [31:0] p1_ab_reg;
    logic [30:0]        p1_aa_reg, p1_bb_reg;

    logic [SADW-1:0]        sad_reg;
    logic [SSDW-1:0]        ssd_reg;
    logic signed [DOTW-1:0] dot_reg;
    logic [NRMW-1:0]        na_reg, nb_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   bound_reg, done_reg;
    logic                   accept;

    assign a    = s_tdata[15:0];
    assign b    = s_tdata[31:16];
    assign d    = 17'(a) - 17'(b);
    assign dsq  = d * d;
    assign ab   = a * b;
    assign aa   = a * a;
    assign bb   = b * b;
    assign absd = d[16] ? 16'(-d) : d[15:0];

    assign s_tready = cmd.accept_en && !done_reg && !(p1_valid_reg && p1_last_reg);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_abs_reg <= absd;
            p1_sq_reg  <= dsq[31:0];
            p1_ab_reg  <= ab;
            p1_aa_reg  <= aa[30:0];
            p1_bb_reg  <= bb[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p1_last_reg  <= 1'b0;
            sad_reg      <= '0;
            ssd_reg      <= '0;
            dot_reg      <= '0;
            na_reg       <= '0;
            nb_reg       <= '0;
            cnt_reg      <= '0;
            bound_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= accept;
            p1_last_reg  <= accept && s_tlast;
            if (cmd.clear_acc)
            begin
                sad_reg   <= '0;
                ssd_reg   <= '0;
                dot_reg   <= '0;
                na_reg    <= '0;
                nb_reg    <= '0;
                cnt_reg   <= '0;
                bound_reg <= 1'b0;
                done_reg  <= 1'b0;
            end
            else if (p1_valid_reg)
            begin
                // Pairs past the length bound are dropped and only flagged.
                if (cnt_reg < CW'(MAX_LENGTH))
                begin
                    sad_reg <= sad_reg + SADW'(p1_abs_reg);
                    ssd_reg <= ssd_reg + SSDW'(p1_sq_reg);
                    dot_reg <= dot_reg + DOTW'(p1_ab_reg);
                    na_reg  <= na_reg + NRMW'(p1_aa_reg);
                    nb_reg  <= nb_reg + NRMW'(p1_bb_reg);
                    cnt_reg <= cnt_reg + 1'b1;
                end
                else
                begin
                    bound_reg <= 1'b1;
                end
                if (p1_last_reg)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.done      = done_reg;
    assign stat.bound     = bound_reg;
    assign stat.zero_norm = (na_reg == '0) || (nb_reg == '0);
    assign sad = sad_reg;
    assign ssd = ssd_reg;
    assign dot = dot_reg;
    assign na  = na_reg;
    assign nb  = nb_reg;

endmodule

FILE: src/vde_math.sv
// Iterative multiply, divide and square root unit with the result register.
module vde_math
    import vde_pkg::*;
#(
    parameter int MAX_LENGTH = 1024
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  vde_cmd_t                        cmd,
    output math_stat_t                      stat,
    input  logic [16+$clog2(MAX_LENGTH+1)-1:0] sad,
    input  logic [32+$clog2(MAX_LENGTH+1)-1:0] ssd,
    input  logic signed [32+$clog2(MAX_LENGTH+1)-1:0] dot,
    input  logic [31+$clog2(MAX_LENGTH+1)-1:0] na,
    input  logic [31+$clog2(MAX_LENGTH+1)-1:0] nb,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata,
    output logic [1:0]                      m_tuser
);

    localparam int EXTW = OPW + 2;

    logic signed [EXTW-1:0] dot_ext;
    logic                   dot_neg;
    logic [OPW-1:0]         mag;

    logic              run_reg, done_reg;
    math_op_t          op_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [PRODW-1:0]  mc_reg, prod_reg, p_reg;
    logic [OPW-1:0]    mp_reg;
    logic [DIVW-1:0]   d_reg;
    logic [PRODW:0]    drem_reg;
    logic [QW-1:0]     dlow_reg, quo_reg;
    logic [RADW-1:0]   rad_reg;
    logic [REMW-1:0]   srem_reg;
    logic [ROOTW-1:0]  root_reg;

    logic [PRODW-1:0]  prod_next;
    logic [PRODW:0]    dtry;
    logic              dge;
    logic [REMW-1:0]   stry, strial;
    logic              sge;
    logic [18:0]       nv;
    logic              last_iter;

    logic              m_tvalid_reg;
    logic [VALW-1:0]   m_tdata_reg;
    logic [1:0]        m_tuser_reg;
    logic [63:0]       sad64;
    logic [VALW-1:0]   l1_val, cos_val, qe, fin_val;

    assign dot_ext = EXTW'(dot);
    assign dot_neg = dot_ext[EXTW-1];
    assign mag     = OPW'(dot_neg ? -dot_ext : dot_ext);

    assign prod_next = prod_reg + (mp_reg[0] ? mc_reg : '0);
    assign dtry      = {drem_reg[PRODW-1:0], dlow_reg[QW-1]};
    assign dge       = dtry >= {1'b0, p_reg};
    assign stry      = {srem_reg[REMW-3:0], rad_reg[RADW-1:RADW-2]};
    assign strial    = {2'b00, root_reg, 2'b01};
    assign sge       = stry >= strial;
    assign last_iter = run_reg && (cnt_reg == CNTW'(1));

    // 2 - 2cos in 16 fraction bits, with the cosine magnitude held in the root.
    assign nv = dot_neg ? 19'(19'd131072 + {root_reg[QCW-1:0], 1'b0})
                        : 19'(19'd131072 - {root_reg[QCW-1:0], 1'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= last_iter;
            if (cmd.start)
            begin
                run_reg <= 1'b1;
            end
            else if (last_iter)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg <= cmd.op;
            case (cmd.op)
                OP_MUL_DOT, OP_MUL_NORM:
                begin
                    mc_reg   <= (cmd.op == OP_MUL_DOT) ? PRODW'(mag) : PRODW'(OPW'(na));
                    mp_reg   <= (cmd.op == OP_MUL_DOT) ? mag : OPW'(nb);
                    prod_reg <= '0;
                    cnt_reg  <= CNTW'(OPW);
                end
                OP_DIV:
                begin
                    drem_reg <= (PRODW + 1)'(d_reg[DIVW-1:QW]);
                    dlow_reg <= d_reg[QW-1:0];
                    quo_reg  <= '0;
                    cnt_reg  <= CNTW'(QW);
                end
                default:
                begin
                    if (cmd.op == OP_SQRT_SSD)
                    begin
                        rad_reg <= {64'(ssd), 32'd0};
                    end
                    else if (cmd.op == OP_SQRT_COS)
                    begin
                        rad_reg <= RADW'(quo_reg);
                    end
                    else
                    begin
                        rad_reg <= {29'd0, nv, 48'd0};
                    end
                    srem_reg <= '0;
                    root_reg <= '0;
                    cnt_reg  <= CNTW'(ROOTW);
                end
            endcase
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            case (op_reg)
                OP_MUL_DOT, OP_MUL_NORM:
                begin
                    prod_reg <= prod_next;
                    mc_reg   <= {mc_reg[PRODW-2:0], 1'b0};
                    mp_reg   <= {1'b0, mp_reg[OPW-1:1]};
                    if (last_iter && op_reg == OP_MUL_DOT)
                    begin
                        d_reg <= {prod_next, 32'd0};
                    end
                    if (last_iter && op_reg == OP_MUL_NORM)
                    begin
                        p_reg <= prod_next;
                    end
                end
                OP_DIV:
                begin
                    drem_reg <= dge ? dtry - {1'b0, p_reg} : dtry;
                    dlow_reg <= {dlow_reg[QW-2:0], 1'b0};
                    quo_reg  <= {quo_reg[QW-2:0], dge};
                end
                default:
                begin
                    srem_reg <= sge ? stry - strial : stry;
                    root_reg <= {root_reg[ROOTW-2:0], sge};
                    rad_reg  <= {rad_reg[RADW-3:0], 2'b00};
                end
            endcase
        end
    end

    // Result formatting.
    assign sad64  = 64'(sad);
    assign l1_val = (sad64 > 64'h0000_0000_7FFF_FFFF) ? 48'h7FFF_FFFF_FFFF
                                                      : {sad64[31:0], 16'd0};
    assign qe      = VALW'(root_reg[QCW-1:0]);
    assign cos_val = dot_neg ? qe : -qe;

    always_comb
    begin
        case (cmd.fin)
            FIN_L1:   fin_val = l1_val;
            FIN_ROOT: fin_val = root_reg;
            FIN_COS:  fin_val = cos_val;
            default:  fin_val = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_tdata_reg <= fin_val;
            m_tuser_reg <= cmd.status;
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign m_tuser       = m_tuser_reg;
    assign stat.busy     = run_reg;
    assign stat.done     = done_reg;
    assign stat.out_free = !m_tvalid_reg || m_tready;

endmodule

FILE: src/vde_ctrl.sv
// Controller that sequences the finishing steps of each vector.
module vde_ctrl
    import vde_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  acc_stat_t  acc,
    input  math_stat_t mst,
    output vde_cmd_t   cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECIDE = 8'b0000_0010,
        S_MULD   = 8'b0000_0100,
        S_MULN   = 8'b0000_1000,
        S_DIV    = 8'b0001_0000,
        S_SQC    = 8'b0010_0000,
        S_SQR    = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] mode_reg;
    fin_sel_t   fin_reg, fin_next;
    logic [1:0] st_reg, st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_L1;
            fin_reg   <= FIN_ZERO;
            st_reg    <= ST_VALID;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            st_reg    <= st_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        fin_next      = fin_reg;
        st_next       = st_reg;
        cmd           = '0;
        cmd.op        = OP_MUL_DOT;
        cmd.fin       = fin_reg;
        cmd.status    = st_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept_en = 1'b1;
                if (acc.done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                st_next  = ST_VALID;
                fin_next = FIN_ZERO;
                if (acc.bound)
                begin
                    st_next    = ST_BOUND;
                    state_next = S_EMIT;
                end
                else if (mode_reg == MODE_L1)
                begin
                    fin_next   = FIN_L1;
                    state_next = S_EMIT;
                end
                else if (mode_reg == MODE_L2)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_SQRT_SSD;
                    fin_next   = FIN_ROOT;
                    state_next = S_SQR;
                end
                else if (acc.zero_norm)
                begin
                    st_next    = ST_ZERO_NORM;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_MUL_DOT;
                    state_next = S_MULD;
                end
            end
            S_MULD:
            begin
                if (mst.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_MUL_NORM;
                    state_next = S_MULN;
                end
            end
            S_MULN:
            begin
                if (mst.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_DIV;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (mst.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_SQRT_COS;
                    state_next = S_SQC;
                end
            end
            S_SQC:
            begin
                if (mst.done)
                begin
                    if (mode_reg == MODE_COS)
                    begin
                        fin_next   = FIN_COS;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        cmd.op     = OP_SQRT_NVD;
                        fin_next   = FIN_ROOT;
                        state_next = S_SQR;
                    end
                end
            end
            S_SQR:
            begin
                if (mst.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (mst.out_free)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.clear_acc = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !mst.busy)
        else $error("math unit started while busy");
    a_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mst.done |-> (state_reg == S_MULD || state_reg == S_MULN || state_reg == S_DIV
                      || state_reg == S_SQC || state_reg == S_SQR))
        else $error("math completion outside a waiting state");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> mst.out_free)
        else $error("result loaded over an untaken result");
`endif

endmodule

FILE: src/vector_distance_engine_core.sv
// Top level of the vector distance engine: accumulator, math unit and controller.
//
//  Channel   Direction  Signals                              Request
//  s_*       in         tvalid tready tdata tlast            one element pair
//  m_*       out        tvalid tready tdata tuser            one distance result
//  cfg_*     in         we wdata                             distance mode write
//
// Element pairs are taken one per cycle while a vector accumulates. After the
// last pair, it passes the product register and then the sum registers, and
// the controller finishes. L1 only formats the sum; L2 takes one 48-step
// square root; negated cosine takes two 48-step shift-add multiplies, a
// 33-step divide and a 48-step root; normalized distance takes one more root.
// Input is held off from the last pair until the result enters the output
// register; the next vector streams in while that result waits to be taken.
// Reset clears all sums and control state at once; there is no clearing pass.
module vector_distance_engine_core
    import vde_pkg::*;
#(
    parameter int MAX_LENGTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // elem_a [15:0], elem_b [31:16]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // distance_value [47:0]
    output logic [1:0]  m_tuser,   // status [1:0]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata  // distance_mode [1:0]
);

    localparam int CW = $clog2(MAX_LENGTH + 1);

    vde_cmd_t   cmd;
    acc_stat_t  acc_stat;
    math_stat_t math_stat;

    // Running sums handed from the accumulator to the math unit.
    logic [16+CW-1:0]        sad;
    logic [32+CW-1:0]        ssd;
    logic signed [32+CW-1:0] dot;
    logic [31+CW-1:0]        na, nb;

    // The accumulator forms the per-pair products and the five sums; it
    // accepts requests only while the controller is idle.
    vde_accum #(.MAX_LENGTH(MAX_LENGTH)) u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .stat     (acc_stat),
        .sad      (sad),
        .ssd      (ssd),
        .dot      (dot),
        .na       (na),
        .nb       (nb)
    );

    // The math unit runs one iterative operation at a time and owns the
    // output register.
    vde_math #(.MAX_LENGTH(MAX_LENGTH)) u_math (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (math_stat),
        .sad      (sad),
        .ssd      (ssd),
        .dot      (dot),
        .na       (na),
        .nb       (nb),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // The controller holds the distance mode and sequences the finish.
    vde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .acc       (acc_stat),
        .mst       (math_stat),
        .cmd       (cmd)
    );

endmodule
